// ----- sv/ptsb_pkg.sv -----
// Shared types and constants for the periodic timer slot bank.
// Used by ptsb_slot and periodic_timer_slot_bank_unit; depends on nothing.

package ptsb_pkg;

   // Widths fixed by the word format.
   localparam int COUNT_W    = 32;
   localparam int SLOT_IDX_W = 3;
   localparam int FIRED_W    = 8;

   // Operation codes carried in the request word.
   typedef enum logic [0:0] {
      OP_TICK     = 1'b0,
      OP_REGISTER = 1'b1
   } op_type;

   // Per-slot control, driven by the top level for one processed word.
   typedef struct packed {
      logic               tick;
      logic               load;
      logic [COUNT_W-1:0] period;
      logic               enable;
   } slot_ctrl_type;

endpackage

// ----- sv/ptsb_slot.sv -----
// One timer slot: a 32-bit down-counter, its reload value and an enable bit.
// Depends on ptsb_pkg for the control struct and the counter width.

module ptsb_slot (
   input  logic                  clock,
   input  logic                  reset,
   input  ptsb_pkg::slot_ctrl_type ctrl,
   output logic                  expired
);
   import ptsb_pkg::*;

   logic [COUNT_W-1:0] counter_ff;
   logic [COUNT_W-1:0] counter_in;
   logic [COUNT_W-1:0] reload_ff;
   logic [COUNT_W-1:0] reload_in;
   logic               enable_ff;
   logic               enable_in;
   logic [COUNT_W-1:0] count_dec;

   // Decrement on a tick; reaching zero reloads the counter and flags expiry.
   // A period of zero wraps through the full counter range.
   always_comb begin
      count_dec  = counter_ff - COUNT_W'(1);
      counter_in = counter_ff;
      reload_in  = reload_ff;
      enable_in  = enable_ff;
      expired    = 1'b0;
      if (ctrl.load) begin
         counter_in = ctrl.period;
         reload_in  = ctrl.period;
         enable_in  = ctrl.enable;
      end else if (ctrl.tick && enable_ff) begin
         if (count_dec == '0) begin
            counter_in = reload_ff;
            expired    = 1'b1;
         end else begin
            counter_in = count_dec;
         end
      end
   end

   // Only the enable is cleared at reset; the counter and reload are written
   // by a registration before the slot can run.
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b0;
      end else begin
         enable_ff <= enable_in;
      end
   end

   always_ff @(posedge clock) begin
      counter_ff <= counter_in;
      reload_ff  <= reload_in;
   end

   // A slot is never loaded and ticked by the same word.
   a_load_tick_excl: assert property (@(posedge clock) disable iff (reset)
      !(ctrl.load && ctrl.tick))
      else $error("slot loaded and ticked together");

   // A registration sets both the count and the reload value.
   a_load_sets: assert property (@(posedge clock) disable iff (reset)
      ctrl.load |=> (counter_ff == $past(ctrl.period)) && (reload_ff == $past(ctrl.period)))
      else $error("registration did not load the slot");

   // An enabled slot at one reloads on the next tick.
   a_expiry_reload: assert property (@(posedge clock) disable iff (reset)
      (enable_ff && ctrl.tick && !ctrl.load && counter_ff == COUNT_W'(1))
      |=> counter_ff == $past(reload_ff))
      else $error("expired slot was not reloaded");

   // Without a tick or a load an enabled counter holds its value.
   a_idle_hold: assert property (@(posedge clock) disable iff (reset)
      (enable_ff && !ctrl.tick && !ctrl.load) |=> $stable(counter_ff))
      else $error("idle slot counter moved");

endmodule

// ----- sv/periodic_timer_slot_bank_unit.sv -----
// Top level of the periodic timer slot bank: request and response channels,
// an input register, the slot array and the response register.
// Depends on ptsb_pkg and ptsb_slot.

// Usage
// The request channel (req_valid, req_stall and the payload ports) carries
// one word per item: a tick (req_operation = OP_TICK) or a slot registration
// (OP_REGISTER) that loads period into the slot's counter and reload value
// and writes its enable. Every word produces exactly one response word on
// rsp_valid/rsp_fired: the mask of slots that expired on a tick, or zero for
// a registration. Only the lowest eight slots show in the mask.
// A word passes from acceptance through the input register, then through the
// parallel decrement of all slots into the response register. Throughput is
// one word per cycle while rsp_stall is low, set by that single pass.
// The input register keeps taking words while an earlier response is held;
// when rsp_stall is high and both registers are full, req_stall rises and
// the response word holds until taken.
// Reset clears both valid flags and all slot enables. Counters and reload
// values are not cleared; a slot runs only after it has been registered.

module periodic_timer_slot_bank_unit #(
   parameter int NUM_SLOTS = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_operation,
   input  logic [ptsb_pkg::SLOT_IDX_W-1:0]     req_slot,
   input  logic [ptsb_pkg::COUNT_W-1:0]        req_period,
   input  logic                                req_enable,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [ptsb_pkg::FIRED_W-1:0]        rsp_fired
);
   import ptsb_pkg::*;

   logic                  in_valid_ff;
   logic                  in_valid_in;
   op_type                in_op_ff;
   logic [SLOT_IDX_W-1:0] in_slot_ff;
   logic [COUNT_W-1:0]    in_period_ff;
   logic                  in_enable_ff;
   logic                  out_valid_ff;
   logic                  out_valid_in;
   logic [FIRED_W-1:0]    fired_ff;
   logic [FIRED_W-1:0]    fired_in;
   logic                  take_in;
   logic                  advance;
   logic [NUM_SLOTS-1:0]  expired;
   slot_ctrl_type         slot_ctrl [NUM_SLOTS];

   // Handshake: the held word moves on whenever the response register is
   // free or being emptied.
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && out_valid_ff && rsp_stall;
   assign take_in   = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (take_in) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (take_in) begin
         in_op_ff     <= op_type'(req_operation);
         in_slot_ff   <= req_slot;
         in_period_ff <= req_period;
         in_enable_ff <= req_enable;
      end
   end

   // Slot array: every slot sees the tick, only the addressed one the load.
   // An index beyond the bank matches no slot and is ignored.
   for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_slot
      always_comb begin
         slot_ctrl[i].tick   = advance && (in_op_ff == OP_TICK);
         slot_ctrl[i].load   = advance && (in_op_ff == OP_REGISTER)
                               && (32'(in_slot_ff) == 32'(i));
         slot_ctrl[i].period = in_period_ff;
         slot_ctrl[i].enable = in_enable_ff;
      end

      ptsb_slot u_slot (
         .clock   (clock),
         .reset   (reset),
         .ctrl    (slot_ctrl[i]),
         .expired (expired[i])
      );
   end

   // Fired mask: the lowest slots only, zero where the bank is smaller.
   for (genvar b = 0; b < FIRED_W; b++) begin : g_fired
      if (b < NUM_SLOTS) begin : g_live
         assign fired_in[b] = expired[b];
      end else begin : g_none
         assign fired_in[b] = 1'b0;
      end
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (advance) begin
         fired_ff <= fired_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_fired = fired_ff;

   // The request side is held back only by a full, stalled pipeline.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall && in_valid_ff))
      else $error("request stalled without a stalled response");

   // A registration word always answers with an empty mask.
   a_register_zero: assert property (@(posedge clock) disable iff (reset)
      (advance && in_op_ff == OP_REGISTER) |=> (rsp_valid && rsp_fired == '0))
      else $error("registration produced a non-zero mask");

   // A response word only leaves when it was taken.
   a_rsp_drop: assert property (@(posedge clock) disable iff (reset)
      $fell(rsp_valid) |-> $past(!rsp_stall))
      else $error("response word dropped while stalled");

endmodule
